/* rtl/gnna_pkg.sv */
// ----------------------------------------------------------------------------
// gnna_pkg
// Shared types and constants for the gated nearest neighbour association unit.
// ----------------------------------------------------------------------------
package gnna_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_NEW_FRAME = 2'd0;
  localparam logic [1:0] ACT_ADD_DET   = 2'd1;
  localparam logic [1:0] ACT_QUERY     = 2'd2;

  localparam int COORD_W = 20;   // Q12.8 coordinate
  localparam int VAR_W   = 24;   // Q8.16 variance
  localparam int DIST_W  = 32;   // Q16.16 distance
  localparam int SQ_W    = 41;   // square of a 21-bit difference
  localparam int DIV_RADIX_BITS = 4;   // quotient bits per divider cycle
  localparam int DIV_CYCLES = DIST_W / DIV_RADIX_BITS;

  localparam logic [DIST_W-1:0] DIST_SAT   = '1;
  localparam logic [DIST_W-1:0] GATE_RESET = 32'd1638400;   // 25.0

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [VAR_W-1:0]          var_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [SQ_W-1:0]           sq_t;

endpackage

/* rtl/gnna_store.sv */
// ----------------------------------------------------------------------------
// gnna_store
// Detection position memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gnna_store
  import gnna_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  coord_t        wx,
  input  coord_t        wy,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output coord_t        rx,
  output coord_t        ry
);

  logic [2*COORD_W-1:0] mem [DEPTH];
  logic [2*COORD_W-1:0] rdata;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wx, wy};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign rx = rdata[2*COORD_W-1:COORD_W];
  assign ry = rdata[COORD_W-1:0];

endmodule

/* rtl/gnna_div.sv */
// ----------------------------------------------------------------------------
// gnna_div
// Shared divider: floor((num << 16) / den), saturated to all ones,
// four quotient bits a cycle.
// ----------------------------------------------------------------------------
module gnna_div
  import gnna_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  sq_t   num,
  input  var_t  den,
  output logic  done,
  output dist_t quo
);

  logic                          busy;
  logic [$clog2(DIV_CYCLES)-1:0] step;
  var_t                          den_r;
  var_t                          rem;
  dist_t                         q;
  var_t                          rem_next;
  dist_t                         q_next;
  logic                          sat;

  // quotient overflows when num >= den * 2^16; zero divisor also saturates
  assign sat = (den == '0) || (num >= {1'b0, den, 16'h0000});

  // four restoring steps
  always_comb begin
    logic [VAR_W:0] t;
    rem_next = rem;
    q_next   = q;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      t      = {rem_next, q_next[DIST_W-1]};
      q_next = {q_next[DIST_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t         = t - {1'b0, den_r};
        q_next[0] = 1'b1;
      end
      rem_next = t[VAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        step  <= '0;
        if (sat) begin
          quo  <= DIST_SAT;
          done <= 1'b1;
        end else begin
          // high part of the shifted numerator is already below den
          rem  <= num[VAR_W+15:16];
          q    <= {num[15:0], 16'h0000};
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= rem_next;
        q    <= q_next;
        step <= step + 1'b1;
        if (step == ($clog2(DIV_CYCLES))'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= q_next;
        end
      end
    end
  end

endmodule

/* rtl/gated_nearest_neighbour_association_unit.sv */
// ----------------------------------------------------------------------------
// gated_nearest_neighbour_association_unit
// Greedy nearest neighbour association of detections to track queries with
// a gate on the diagonal Mahalanobis distance.
// ----------------------------------------------------------------------------
//  channel | signals                       | word
//  --------+-------------------------------+--------------------------------
//  in      | in_valid / in_ready           | action, det_*, track_*, var_*
//  out     | out_valid / out_ready         | track_index .. best_distance
//  cfg     | cfg_valid / cfg_ready         | gate_squared
//
//  New frame and add detection are handled in the idle state itself. For each
//  stored detection a track query runs, per axis, a squaring state, a divider
//  start state and a wait on the shared divider (which skips the division when
//  the term saturates), then one compare state; with no detections it finishes.
//  rst is synchronous; it clears the frame, flags and counters, gate to 25.0.
//  A finished result sits in the output register; a new word is taken while
//  it waits, but the next query result stalls until it has been taken.
// ----------------------------------------------------------------------------
module gated_nearest_neighbour_association_unit
  import gnna_pkg::*;
#(
  parameter int MAX_DETECTIONS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  coord_t      det_x,
  input  coord_t      det_y,
  input  coord_t      track_x,
  input  coord_t      track_y,
  input  var_t        var_x,
  input  var_t        var_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] track_index,
  output logic        matched,
  output logic [5:0]  detection_index,
  output logic        contention,
  output dist_t       best_distance,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  dist_t       gate_squared
);

  localparam int AW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int CW = $clog2(MAX_DETECTIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_START, S_WAIT, S_CMP, S_FIN
  } state_t;

  state_t            state;
  logic              axis;
  logic [CW-1:0]     det_count;
  logic [CW-1:0]     idx;
  logic [15:0]       query_count;
  logic [MAX_DETECTIONS-1:0] taken;
  dist_t             gate;
  coord_t            tx, ty;
  var_t              vx, vy;
  sq_t               sq;
  dist_t             term_x;
  dist_t             term_y;
  dist_t             best;
  logic [AW-1:0]     best_idx;

  logic              in_acc;
  logic              st_we, st_re;
  logic [AW-1:0]     st_raddr;
  coord_t            rd_x, rd_y;
  logic              div_done;
  dist_t             div_quo;
  logic              more;
  logic              res_load;
  logic [DIST_W:0]   sum_full;
  dist_t             sum;
  coord_t            cur_c, cur_t;
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]  mag;
  logic [2*COORD_W+1:0] prod;
  logic [AW+5:0]     idx_ext;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // result register loads when it is free or being emptied
  assign res_load  = (state == S_FIN) && (!out_valid || out_ready);

  // store access
  assign more  = ((CW+1)'(idx) + 1'b1) < {1'b0, det_count};
  assign st_we = in_acc && (action == ACT_ADD_DET) &&
                 (det_count < CW'(MAX_DETECTIONS));
  always_comb begin
    st_re    = 1'b0;
    st_raddr = '0;
    if (in_acc && action == ACT_QUERY) begin
      st_re = 1'b1;
    end else if (state == S_CMP && more) begin
      st_re    = 1'b1;
      st_raddr = idx[AW-1:0] + 1'b1;
    end
  end

  gnna_store #(.DEPTH(MAX_DETECTIONS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (det_count[AW-1:0]),
    .wx    (det_x),
    .wy    (det_y),
    .re    (st_re),
    .raddr (st_raddr),
    .rx    (rd_x),
    .ry    (rd_y)
  );

  gnna_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .num   (sq),
    .den   (axis ? vy : vx),
    .done  (div_done),
    .quo   (div_quo)
  );

  // difference and magnitude for the current axis
  assign cur_c = axis ? rd_y : rd_x;
  assign cur_t = axis ? ty : tx;
  assign diff  = {cur_c[COORD_W-1], cur_c} - {cur_t[COORD_W-1], cur_t};
  assign mag   = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
  assign prod  = mag * mag;

  // saturating sum of the two terms
  assign sum_full = {1'b0, term_x} + {1'b0, term_y};
  assign sum      = sum_full[DIST_W] ? DIST_SAT : sum_full[DIST_W-1:0];

  assign idx_ext = {6'b0, best_idx};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      axis        <= 1'b0;
      det_count   <= '0;
      idx         <= '0;
      query_count <= '0;
      taken       <= '0;
      gate        <= GATE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gate <= gate_squared;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (action)
              ACT_NEW_FRAME: begin
                det_count   <= '0;
                query_count <= '0;
                taken       <= '0;
              end
              ACT_ADD_DET: begin
                if (st_we) begin
                  det_count <= det_count + 1'b1;
                end
              end
              ACT_QUERY: begin
                tx       <= track_x;
                ty       <= track_y;
                vx       <= var_x;
                vy       <= var_y;
                idx      <= '0;
                axis     <= 1'b0;
                best     <= DIST_SAT;
                best_idx <= '0;
                state    <= (det_count == '0) ? S_FIN : S_MUL;
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          sq    <= prod[SQ_W-1:0];
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            if (axis) begin
              term_y <= div_quo;
              state  <= S_CMP;
            end else begin
              term_x <= div_quo;
              axis   <= 1'b1;
              state  <= S_MUL;
            end
          end
        end
        S_CMP: begin
          // first strict minimum wins
          if (idx == '0 || sum < best) begin
            best     <= sum;
            best_idx <= idx[AW-1:0];
          end
          axis <= 1'b0;
          if (more) begin
            idx   <= idx + 1'b1;
            state <= S_MUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_load) begin
            track_index     <= query_count;
            detection_index <= idx_ext[5:0];
            best_distance   <= best;
            matched         <= 1'b0;
            contention      <= 1'b0;
            if (det_count != '0 && best <= gate) begin
              if (taken[best_idx]) begin
                contention <= 1'b1;
              end else begin
                taken[best_idx] <= 1'b1;
                matched         <= 1'b1;
              end
            end
            query_count <= query_count + 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/gnna_checker.sv */
// ----------------------------------------------------------------------------
// gnna_checker
// Port-level checks on the association unit, bound to the top level.
// ----------------------------------------------------------------------------
module gnna_checker
  import gnna_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] track_index,
  input logic        matched,
  input logic        contention,
  input dist_t       best_distance
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(track_index) &&
    $stable(best_distance) && $stable(matched))
    else $error("result word changed while stalled");

  // a match and a contention never come together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(matched && contention))
    else $error("matched and contention both set");

  // a query keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_QUERY |=> !in_ready)
    else $error("input taken straight after a query");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind gated_nearest_neighbour_association_unit gnna_checker u_gnna_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .action        (action),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .track_index   (track_index),
  .matched       (matched),
  .contention    (contention),
  .best_distance (best_distance)
);

/* tb/sv/gated_nearest_neighbour_association_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gated_nearest_neighbour_association_unit_tb
// Self-checking bench for the association unit. A queue-fed driver offers
// frame, detection, track query and spare action words. A clocked monitor checks every
// result word against a behavioural predictor in the bench. The gate is
// rewritten between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module gated_nearest_neighbour_association_unit_tb;
  import gnna_pkg::*;

  localparam int DET_DEPTH = 64;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [1:0] act;
    coord_t     dx, dy, tx, ty;
    var_t       vx, vy;
  } in_word_t;

  typedef struct {
    logic [15:0] trk_idx;
    logic        hit;
    logic [5:0]  det_idx;
    logic        clash;
    dist_t       best_dist;
  } assoc_word_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_NEW_FRAME;
  coord_t      det_x = '0, det_y = '0, track_x = '0, track_y = '0;
  var_t        var_x = 24'd1, var_y = 24'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] track_index;
  logic        matched;
  logic [5:0]  detection_index;
  logic        contention;
  dist_t       best_distance;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  dist_t       gate_squared = GATE_RESET;

  gated_nearest_neighbour_association_unit #(.MAX_DETECTIONS(DET_DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .det_x(det_x), .det_y(det_y),
    .track_x(track_x), .track_y(track_y), .var_x(var_x), .var_y(var_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .track_index(track_index), .matched(matched),
    .detection_index(detection_index), .contention(contention),
    .best_distance(best_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .gate_squared(gate_squared)
  );

  // bench state
  in_word_t    pending_words[$];
  assoc_word_t expected_assoc[$];
  in_word_t    cur_word;
  bit          in_fire = 1'b0;
  bit          calm = 1'b0;
  int          gap_left = 0;
  int          rx_hold_reqs = 0, rx_hold_seen = 0, rx_hold_left = 0;
  int          errors = 0, words_pushed = 0, results_seen = 0;
  int          hits_seen = 0, clashes_seen = 0;

  // predictor copy of the block state
  coord_t      pred_x[DET_DEPTH], pred_y[DET_DEPTH];
  bit          pred_taken[DET_DEPTH];
  int          pred_count = 0;
  logic [15:0] pred_query = '0;
  dist_t       pred_gate = GATE_RESET;

  function automatic logic [63:0] axis_cost(coord_t d, coord_t t, var_t v);
    logic signed [20:0] diff;
    logic [20:0] mag;
    logic [63:0] q;
    diff = {d[19], d} - {t[19], t};
    mag  = diff[20] ? -diff : diff;
    q    = ({43'd0, mag} * {43'd0, mag}) << 16;
    q    = q / {40'd0, v};
    return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
  endfunction

  task automatic predict_association(input in_word_t w);
    logic [63:0] best, d;
    int best_i;
    bit found;
    assoc_word_t r;
    best = 64'hFFFF_FFFF;
    best_i = 0;
    found = 0;
    case (w.act)
      ACT_NEW_FRAME: begin
        pred_count = 0;
        pred_query = '0;
        foreach (pred_taken[i]) pred_taken[i] = 0;
      end
      ACT_ADD_DET: begin
        if (pred_count < DET_DEPTH) begin
          pred_x[pred_count] = w.dx;
          pred_y[pred_count] = w.dy;
          pred_count++;
        end
      end
      ACT_QUERY: begin
        for (int i = 0; i < pred_count; i++) begin
          d = axis_cost(pred_x[i], w.tx, w.vx) + axis_cost(pred_y[i], w.ty, w.vy);
          if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
          if (!found || d < best) begin
            found = 1;
            best = d;
            best_i = i;
          end
        end
        r.trk_idx = pred_query;
        r.hit = 0;
        r.clash = 0;
        r.det_idx = best_i[5:0];
        r.best_dist = best[31:0];
        if (found && best[31:0] <= pred_gate) begin
          if (pred_taken[best_i]) r.clash = 1;
          else begin
            pred_taken[best_i] = 1;
            r.hit = 1;
          end
        end
        expected_assoc = {expected_assoc, r};
        pred_query++;
      end
      default: ;
    endcase
  endtask

  // short gaps mostly, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 45) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // input acceptance and prediction at the rising edge
  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) predict_association(cur_word);
  end

  // input driver, words change at the falling edge
  always @(negedge clk) begin
    if (!rst && (in_fire || !in_valid)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        action  <= cur_word.act;
        det_x   <= cur_word.dx;
        det_y   <= cur_word.dy;
        track_x <= cur_word.tx;
        track_y <= cur_word.ty;
        var_x   <= cur_word.vx;
        var_y   <= cur_word.vy;
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver readiness, with a long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = 3000;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : (pick_gap() == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    assoc_word_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_assoc.size() == 0) begin
        $display("%0t: unexpected result word, track_index %0d", $time, track_index);
        errors++;
      end else begin
        e = expected_assoc.pop_front();
        if (matched) hits_seen++;
        if (contention) clashes_seen++;
        if (track_index !== e.trk_idx) begin
          $display("%0t: track_index exp %0d got %0d", $time, e.trk_idx, track_index);
          errors++;
        end
        if (matched !== e.hit) begin
          $display("%0t: matched exp %0b got %0b", $time, e.hit, matched);
          errors++;
        end
        if (detection_index !== e.det_idx) begin
          $display("%0t: detection_index exp %0d got %0d", $time, e.det_idx,
                   detection_index);
          errors++;
        end
        if (contention !== e.clash) begin
          $display("%0t: contention exp %0b got %0b", $time, e.clash, contention);
          errors++;
        end
        if (best_distance !== e.best_dist) begin
          $display("%0t: best_distance exp %h got %h", $time, e.best_dist,
                   best_distance);
          errors++;
        end
      end
    end
  end

  // stimulus helpers
  task automatic push_word(input logic [1:0] a, input int dx, input int dy,
                           input int tx, input int ty, input int vx, input int vy);
    in_word_t w;
    w.act = a;
    w.dx = dx[19:0];
    w.dy = dy[19:0];
    w.tx = tx[19:0];
    w.ty = ty[19:0];
    w.vx = vx[23:0];
    w.vy = vy[23:0];
    pending_words = {pending_words, w};
    words_pushed++;
  endtask

  function automatic int clamp_coord(input int v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, 20'hFFFFF)) - 524288;
  endfunction

  function automatic int rnd_var();
    return $urandom_range(1, 24'hFFFFFF);
  endfunction

  // wait for the block to go quiet, then a few spare cycles
  task automatic drain();
    @(posedge clk);
    while (pending_words.size() > 0 || in_valid || expected_assoc.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_gate(input dist_t g);
    @(negedge clk);
    cfg_valid <= 1'b1;
    gate_squared <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred_gate = g;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame of traffic with random content, stray words of any action included
  task automatic random_frame(input int n_det, input int n_query);
    int fx[DET_DEPTH], fy[DET_DEPTH];
    int k, span, stored;
    push_word(ACT_NEW_FRAME, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
              rnd_var(), rnd_var());
    span = 1 << $urandom_range(8, 14);
    for (int i = 0; i < n_det; i++) begin
      k = (i < DET_DEPTH) ? i : DET_DEPTH - 1;
      fx[k] = ($urandom_range(0, 4) == 0) ? rnd_coord()
              : int'($urandom_range(0, 2 * span)) - span;
      fy[k] = ($urandom_range(0, 4) == 0) ? rnd_coord()
              : int'($urandom_range(0, 2 * span)) - span;
      if (i < DET_DEPTH) push_word(ACT_ADD_DET, fx[k], fy[k], rnd_coord(),
                                   rnd_coord(), rnd_var(), rnd_var());
      else push_word(ACT_ADD_DET, rnd_coord(), rnd_coord(), 0, 0, 1, 1);
    end
    stored = (n_det < DET_DEPTH) ? n_det : DET_DEPTH;
    for (int q = 0; q < n_query; q++) begin
      if (stored > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, stored - 1);
        push_word(ACT_QUERY, rnd_coord(), rnd_coord(),
                  clamp_coord(fx[k] + int'($urandom_range(0, 3000)) - 1500),
                  clamp_coord(fy[k] + int'($urandom_range(0, 3000)) - 1500),
                  $urandom_range(1 << 12, 1 << 20), $urandom_range(1 << 12, 1 << 20));
      end else begin
        push_word(ACT_QUERY, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_var(), rnd_var());
      end
      // stray noise between queries
      if ($urandom_range(0, 9) == 0)
        push_word($urandom_range(0, 3), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_var(), rnd_var());
    end
  endtask

  function automatic dist_t pick_gate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DIST_SAT;
      2: return $urandom();
      default: return $urandom_range(1 << 16, 1 << 24);
    endcase
  endfunction

  // main sequence
  initial begin
    int phase;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty store, exact hit, repeat hit, far track, ties, extremes
    write_gate(GATE_RESET);
    push_word(ACT_QUERY, 0, 0, 0, 0, 1 << 16, 1 << 16);
    push_word(ACT_NEW_FRAME, 0, 0, 0, 0, 1, 1);
    push_word(ACT_ADD_DET, -524288, 524287, 0, 0, 1, 1);
    push_word(ACT_ADD_DET, 256, 256, 0, 0, 1, 1);
    push_word(ACT_ADD_DET, -256, -256, 0, 0, 1, 1);
    push_word(ACT_ADD_DET, 524287, -524288, 0, 0, 1, 1);
    push_word(ACT_QUERY, 0, 0, 256, 256, 1 << 16, 1 << 16);
    push_word(ACT_QUERY, 0, 0, 256, 256, 1 << 16, 1 << 16);
    push_word(ACT_QUERY, 0, 0, 0, 0, 1 << 16, 1 << 16);
    push_word(ACT_QUERY, 0, 0, 0, 0, 1 << 16, 1 << 16);
    push_word(ACT_QUERY, 0, 0, 100000, -100000, 1 << 16, 1 << 16);
    push_word(ACT_QUERY, 0, 0, 524287, 524287, 1, 1);
    push_word(ACT_QUERY, 0, 0, -524288, 524287, 24'hFFFFFF, 24'hFFFFFF);
    push_word(ACT_SPARE, 1, 1, 1, 1, 1, 1);
    push_word(ACT_QUERY, 0, 0, 524287, -524288, 1, 24'hFFFFFF);
    push_word(ACT_NEW_FRAME, 0, 0, 0, 0, 1, 1);
    push_word(ACT_QUERY, 0, 0, 0, 0, 1, 1);
    drain();
    write_gate(DIST_SAT);
    push_word(ACT_NEW_FRAME, 0, 0, 0, 0, 1, 1);
    push_word(ACT_ADD_DET, 524287, 524287, 0, 0, 1, 1);
    push_word(ACT_ADD_DET, -524288, -524288, 0, 0, 1, 1);
    push_word(ACT_QUERY, 0, 0, 0, 0, 1, 1);
    push_word(ACT_QUERY, 0, 0, 0, 0, 1, 1);
    drain();

    // full store with overflow adds, receiver held off to back the block up
    write_gate('0);
    rx_hold_reqs++;
    random_frame(70, 6);
    drain();

    // random phases, each with its own gate
    phase = 0;
    while (words_pushed < 900) begin
      calm = (phase % 5 == 3);
      write_gate(pick_gate());
      for (int f = 0; f < 3; f++)
        random_frame(($urandom_range(0, 29) == 0) ? 64 : $urandom_range(0, 8),
                     $urandom_range(1, 6));
      drain();
      phase++;
    end
    calm = 0;
    write_gate(GATE_RESET);
    random_frame(5, 5);
    drain();
    repeat (50) @(posedge clk);

    $display("Ran %0d words over %0d gate phases: %0d results, %0d matches, %0d contentions.",
             words_pushed, phase + 4, results_seen, hits_seen, clashes_seen);
    if (errors == 0 && expected_assoc.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run time limit
  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/gnna_pkg.sv
rtl/gnna_store.sv
rtl/gnna_div.sv
rtl/gated_nearest_neighbour_association_unit.sv
rtl/gnna_checker.sv
tb/sv/gated_nearest_neighbour_association_unit_tb.sv
